[rtl/core/fhsd_pkg.sv]
// Shared constants, payload types and unit interface structs for the segment draw unit.
`timescale 1ns / 1ps

package fhsd_pkg;

    localparam int HORIZON_WIDTH = 1024;
    localparam int MAX_SPAN      = 64;

    localparam int X_W    = 10;
    localparam int Y_W    = 8;
    localparam int HZ_AW  = (HORIZON_WIDTH > 1) ? $clog2(HORIZON_WIDTH) : 1;
    localparam int SPAN_W = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
    localparam int DY_W   = Y_W + 1;     // signed endpoint row difference
    localparam int Q_W    = Y_W + 2;     // signed integer part of the row offset

    localparam logic [Y_W-1:0] HORIZON_RESET = 8'd199;

    typedef struct packed {
        logic [X_W-1:0] x_a;
        logic [Y_W-1:0] y_a;
        logic [X_W-1:0] x_b;
        logic [Y_W-1:0] y_b;
    } t_seg_in;

    typedef struct packed {
        logic [X_W-1:0] pixel_x;
        logic [Y_W-1:0] pixel_y;
        logic           drawn;
        logic           last;
    } t_pix_out;

    typedef struct packed {
        logic           start;
        logic [Y_W-1:0] dividend;
        logic [X_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic           done;
        logic [Y_W-1:0] quot;
        logic [X_W-1:0] rem;
    } t_div_rsp;

    typedef struct packed {
        logic             we;
        logic [HZ_AW-1:0] waddr;
        logic [Y_W-1:0]   wdata;
        logic             re;
        logic [HZ_AW-1:0] raddr;
    } t_mem_req;

endpackage

[rtl/core/floating_horizon_segment_draw_unit.sv]
// Floating-horizon segment drawer: slope setup, column stepper and horizon update.
//
// Input channel (i_in_valid / o_in_stall / i_in) takes one segment per transaction.
// Output channel (o_out_valid / i_out_stall / o_out) gives one transaction per
// column, last set on the final column of the segment; a segment whose endpoints
// share a column gives nothing.
// After reset the horizon store is swept to row 199, one entry per cycle;
// o_in_stall stays high until the sweep is done.
// A segment is taken only while the unit is idle. Slope setup runs a bit-serial
// divider before the first column result. Columns then follow one per cycle
// while the receiver does not stall, each a read of the horizon store ahead of it
// and a write in the cycle the result is registered. The next segment can be
// taken while the last column still sits in the output register. While the
// receiver stalls, the output holds and column stepping pauses with the pending
// horizon read data kept.
`timescale 1ns / 1ps

module floating_horizon_segment_draw_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  fhsd_pkg::t_seg_in  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output fhsd_pkg::t_pix_out o_out
);
    import fhsd_pkg::*;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_DIV, S_COL} t_state;

    t_state            r_state, n_state;
    logic [HZ_AW-1:0]  r_clr, n_clr;
    logic              r_out_valid, n_out_valid;
    t_pix_out          r_out, n_out;
    logic [X_W-1:0]    r_xl, n_xl;
    logic [Y_W-1:0]    r_yl, n_yl;
    logic [X_W-1:0]    r_dx, n_dx;
    logic              r_dy_neg, n_dy_neg;
    logic [SPAN_W-1:0] r_span_m1, n_span_m1;
    logic [SPAN_W-1:0] r_s, n_s;
    logic [X_W-1:0]    r_col, n_col;
    logic [Q_W-1:0]    r_q, n_q;
    logic [Q_W-1:0]    r_dq, n_dq;
    logic [X_W-1:0]    r_r, n_r;
    logic [X_W-1:0]    r_dr, n_dr;

    t_div_req          div_req;
    t_div_rsp          div_rsp;
    t_mem_req          mem_req;
    logic [Y_W-1:0]    mem_rdata;

    // input ordering
    logic              in_le;
    logic [X_W-1:0]    in_xl;
    logic [Y_W-1:0]    in_yl;
    logic [X_W-1:0]    in_dx;
    logic [DY_W-1:0]   in_dy;
    logic [DY_W-1:0]   in_dy_mag;

    // slope setup
    logic              rem_nz;
    logic [Q_W-1:0]    quot_ext;
    logic [Q_W-1:0]    dq_calc;
    logic [X_W-1:0]    dr_calc;

    // column step
    logic [X_W:0]      r_sum;
    logic              wrap;
    logic [Q_W-1:0]    row_sum;
    logic [Y_W-1:0]    row;
    logic              in_range;
    logic              drawn;
    logic              is_last;
    logic              out_free;
    logic [X_W-1:0]    col_next;

    assign in_le     = i_in.x_a <= i_in.x_b;
    assign in_xl     = in_le ? i_in.x_a : i_in.x_b;
    assign in_yl     = in_le ? i_in.y_a : i_in.y_b;
    assign in_dx     = in_le ? (i_in.x_b - i_in.x_a) : (i_in.x_a - i_in.x_b);
    assign in_dy     = in_le ? ({1'b0, i_in.y_b} - {1'b0, i_in.y_a})
                             : ({1'b0, i_in.y_a} - {1'b0, i_in.y_b});
    assign in_dy_mag = in_dy[DY_W-1] ? (~in_dy + DY_W'(1)) : in_dy;

    // floor(dy/dx) and its nonnegative remainder for a negative dy
    assign rem_nz   = |div_rsp.rem;
    assign quot_ext = {2'b00, div_rsp.quot};
    assign dq_calc  = r_dy_neg ? (~quot_ext + Q_W'(1) - Q_W'(rem_nz)) : quot_ext;
    assign dr_calc  = (r_dy_neg && rem_nz) ? (r_dx - div_rsp.rem) : div_rsp.rem;

    assign r_sum    = {1'b0, r_r} + {1'b0, r_dr};
    assign wrap     = r_sum >= {1'b0, r_dx};
    assign row_sum  = {2'b00, r_yl} + r_q;
    assign row      = row_sum[Y_W-1:0];
    assign in_range = 32'(r_col) < 32'(HORIZON_WIDTH);
    assign drawn    = in_range && (mem_rdata >= row);
    assign is_last  = r_s == r_span_m1;
    assign out_free = !r_out_valid || !i_out_stall;
    assign col_next = r_col + X_W'(1);

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_xl        = r_xl;
        n_yl        = r_yl;
        n_dx        = r_dx;
        n_dy_neg    = r_dy_neg;
        n_span_m1   = r_span_m1;
        n_s         = r_s;
        n_col       = r_col;
        n_q         = r_q;
        n_dq        = r_dq;
        n_r         = r_r;
        n_dr        = r_dr;
        div_req     = '0;
        mem_req     = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_clr;
                mem_req.wdata = HORIZON_RESET;
                if (r_clr == HZ_AW'(HORIZON_WIDTH - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + HZ_AW'(1);
                end
            end
            S_IDLE: begin
                if (i_in_valid && (in_dx != '0)) begin
                    n_xl     = in_xl;
                    n_yl     = in_yl;
                    n_dx     = in_dx;
                    n_dy_neg = in_dy[DY_W-1];
                    if (32'(in_dx) >= 32'(MAX_SPAN)) begin
                        n_span_m1 = SPAN_W'(MAX_SPAN - 1);
                    end else begin
                        n_span_m1 = SPAN_W'(in_dx - X_W'(1));
                    end
                    div_req.start    = 1'b1;
                    div_req.dividend = in_dy_mag[Y_W-1:0];
                    div_req.divisor  = in_dx;
                    n_state          = S_DIV;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_dq          = dq_calc;
                    n_dr          = dr_calc;
                    n_q           = '0;
                    n_r           = '0;
                    n_s           = '0;
                    n_col         = r_xl;
                    mem_req.re    = 1'b1;
                    mem_req.raddr = HZ_AW'(r_xl);
                    n_state       = S_COL;
                end
            end
            S_COL: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out.pixel_x = r_col;
                    n_out.pixel_y = row;
                    n_out.drawn   = drawn;
                    n_out.last    = is_last;
                    mem_req.we    = drawn;
                    mem_req.waddr = HZ_AW'(r_col);
                    mem_req.wdata = row;
                    if (is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        // next column differs from the one written now
                        n_s           = r_s + SPAN_W'(1);
                        n_col         = col_next;
                        n_r           = wrap ? X_W'(r_sum - {1'b0, r_dx}) : r_sum[X_W-1:0];
                        n_q           = r_q + r_dq + Q_W'(wrap);
                        mem_req.re    = 1'b1;
                        mem_req.raddr = HZ_AW'(col_next);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
        r_out     <= n_out;
        r_xl      <= n_xl;
        r_yl      <= n_yl;
        r_dx      <= n_dx;
        r_dy_neg  <= n_dy_neg;
        r_span_m1 <= n_span_m1;
        r_s       <= n_s;
        r_col     <= n_col;
        r_q       <= n_q;
        r_dq      <= n_dq;
        r_r       <= n_r;
        r_dr      <= n_dr;
    end

    fhsd_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    fhsd_hz_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[rtl/core/fhsd_hz_mem.sv]
// Horizon store: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module fhsd_hz_mem (
    input  logic                   i_clk,
    input  fhsd_pkg::t_mem_req     i_req,
    output logic [fhsd_pkg::Y_W-1:0] o_rdata
);
    import fhsd_pkg::*;

    logic [Y_W-1:0] r_mem [HORIZON_WIDTH];
    logic [Y_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/fhsd_divider.sv]
// Restoring divider, one quotient bit per cycle: |dy| / dx for the slope setup.
`timescale 1ns / 1ps

module fhsd_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fhsd_pkg::t_div_req i_req,
    output fhsd_pkg::t_div_rsp o_rsp
);
    import fhsd_pkg::*;

    localparam int CNT_W = (Y_W > 1) ? $clog2(Y_W) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [Y_W-1:0]   r_quo;
    logic [X_W-1:0]   r_rem;
    logic [X_W-1:0]   r_dvs;
    logic [X_W:0]     trial;
    logic             fits;

    assign trial = {r_rem, r_quo[Y_W-1]};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                // remainder stays below the divisor, so it fits X_W bits
                r_rem <= fits ? X_W'(trial - {1'b0, r_dvs}) : trial[X_W-1:0];
                r_quo <= {r_quo[Y_W-2:0], fits};
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(Y_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

[rtl/core/fhsd_checker.sv]
// Port-level checks for the segment draw unit, bound to the top level.
`timescale 1ns / 1ps

module fhsd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input fhsd_pkg::t_seg_in  i_in,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input fhsd_pkg::t_pix_out o_out
);
    import fhsd_pkg::*;

    // held result must not move while the receiver stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // a segment with a nonzero column span keeps the unit busy afterwards
    a_busy_after_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in.x_a != i_in.x_b) |=> o_in_stall)
        else $error("unit took a segment but did not go busy");

    // reset empties the output and starts the horizon sweep
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall && !o_out_valid)
        else $error("reset did not clear output or start sweep");

endmodule

bind floating_horizon_segment_draw_unit fhsd_checker u_fhsd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

[test/floating_horizon_segment_draw_unit_tb.sv]
// Self-checking testbench for the floating-horizon segment draw unit.
`timescale 1ns / 1ps

module floating_horizon_segment_draw_unit_tb;

    import fhsd_pkg::*;

    localparam int RESET_CYCLES = 10;
    localparam int DRAIN_CYCLES = 100;     // segment setup plus a full span
    localparam int WDOG_LIMIT   = 6000;    // covers the post-reset horizon sweep
    localparam int RAND_SEGS    = 250;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     in_valid    = 1'b0;
    t_seg_in  in_seg      = '0;
    logic     out_stall   = 1'b0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_pix_out o_out;

    t_seg_in  seg_q[$];            // segments waiting to be driven
    t_pix_out pixel_exp_q[$];      // predicted column results, oldest first
    logic [Y_W-1:0] horizon_mdl[HORIZON_WIDTH];

    int total_segs   = 0;
    int seg_acc_cnt  = 0;
    int flat_cnt     = 0;
    int long_cnt     = 0;
    int col_cnt      = 0;
    int drawn_cnt    = 0;
    int err_cnt      = 0;
    int wdog_cnt     = 0;
    t_pix_out want_px;

    floating_horizon_segment_draw_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (in_seg),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out       (o_out)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // 0: slow receiver, 1: slow sender, 2: no idling
    function automatic int traffic_phase(input int n);
        int p;
        p = (total_segs > 0) ? (n * 3) / total_segs : 0;
        return (p > 2) ? 2 : p;
    endfunction

    task automatic add_seg(input int xa, input int ya, input int xb, input int yb);
        t_seg_in s;
        s.x_a = X_W'(xa);
        s.y_a = Y_W'(ya);
        s.x_b = X_W'(xb);
        s.y_b = Y_W'(yb);
        seg_q.push_back(s);
        total_segs++;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        err_cnt++;
        $display("ERROR @%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // Rasterize one segment against the horizon copy and queue its column results.
    task automatic draw_segment(input t_seg_in seg);
        int xl, yl, dx, dy, span, num, q, col, row;
        t_pix_out px;
        if (seg.x_a <= seg.x_b) begin
            xl = int'(seg.x_a);
            yl = int'(seg.y_a);
            dx = int'(seg.x_b) - int'(seg.x_a);
            dy = int'(seg.y_b) - int'(seg.y_a);
        end else begin
            xl = int'(seg.x_b);
            yl = int'(seg.y_b);
            dx = int'(seg.x_a) - int'(seg.x_b);
            dy = int'(seg.y_a) - int'(seg.y_b);
        end
        if (dx == 0) begin
            flat_cnt++;
            return;
        end
        if (dx > MAX_SPAN)
            long_cnt++;
        span = (dx < MAX_SPAN) ? dx : MAX_SPAN;
        for (int s = 0; s < span; s++) begin
            num = dy * s;
            q   = num / dx;                      // truncates toward zero
            if ((num % dx) != 0 && num < 0)
                q--;
            col = xl + s;
            row = yl + q;
            px.pixel_x = X_W'(col);
            px.pixel_y = Y_W'(row);
            px.drawn   = 1'b0;
            if (col < HORIZON_WIDTH && horizon_mdl[col] >= px.pixel_y) begin
                horizon_mdl[col] = px.pixel_y;
                px.drawn = 1'b1;
            end
            px.last = (s == span - 1);
            pixel_exp_q.push_back(px);
        end
    endtask

    // Driver: segment transactions from seg_q.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                draw_segment(in_seg);
                seg_acc_cnt++;
            end
            if (!in_valid || !o_in_stall) begin
                if (seg_q.size() > 0 &&
                    $urandom_range(99) >= ((traffic_phase(seg_acc_cnt) == 0) ? 6 :
                                           (traffic_phase(seg_acc_cnt) == 1) ? 82 : 0)) begin
                    in_valid <= 1'b1;
                    in_seg   <= seg_q.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each column transaction against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                col_cnt++;
                if (pixel_exp_q.size() == 0) begin
                    report_mismatch("column result with nothing pending, pixel_x",
                                    o_out.pixel_x, -1);
                end else begin
                    want_px = pixel_exp_q.pop_front();
                    if (want_px.drawn)
                        drawn_cnt++;
                    if (o_out.pixel_x !== want_px.pixel_x)
                        report_mismatch("pixel_x", o_out.pixel_x, want_px.pixel_x);
                    if (o_out.pixel_y !== want_px.pixel_y)
                        report_mismatch($sformatf("pixel_y at x=%0d", want_px.pixel_x),
                                        o_out.pixel_y, want_px.pixel_y);
                    if (o_out.drawn !== want_px.drawn)
                        report_mismatch($sformatf("drawn at x=%0d", want_px.pixel_x),
                                        o_out.drawn, want_px.drawn);
                    if (o_out.last !== want_px.last)
                        report_mismatch($sformatf("last at x=%0d", want_px.pixel_x),
                                        o_out.last, want_px.last);
                end
            end
            out_stall <= ($urandom_range(99) < ((traffic_phase(seg_acc_cnt) == 0) ? 82 :
                                                (traffic_phase(seg_acc_cnt) == 1) ? 6 : 0));
        end
    end

    // Watchdog: too long without any transaction on either side.
    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall))
            wdog_cnt <= 0;
        else
            wdog_cnt <= wdog_cnt + 1;
        if (wdog_cnt >= WDOG_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles, %0d columns pending",
                     WDOG_LIMIT, pixel_exp_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int dx, xl, ya, yb, sel;
        for (int i = 0; i < HORIZON_WIDTH; i++)
            horizon_mdl[i] = HORIZON_RESET;

        // directed segments
        add_seg(100, 10, 100, 200);        // vertical, no columns
        add_seg(0, 0, 0, 255);             // vertical at left edge
        add_seg(1023, 255, 1023, 0);       // vertical at right edge
        add_seg(0, 0, 1, 255);             // single column at left edge
        add_seg(1023, 255, 1022, 0);       // reversed, single column at x=1022
        add_seg(0, 255, 1023, 0);          // long, shallow negative slope, clamped
        add_seg(1023, 128, 900, 0);        // long, reversed order
        add_seg(10, 50, 30, 50);           // flat
        add_seg(30, 50, 10, 50);           // same columns and row: equal horizon draws
        add_seg(10, 60, 30, 60);           // below horizon: hidden
        add_seg(12, 40, 28, 70);           // crosses horizon part way
        add_seg(200, 100, 207, 97);        // negative slope with remainders
        add_seg(300, 0, 364, 255);         // exactly MAX_SPAN columns
        add_seg(365, 255, 300, 0);         // one beyond MAX_SPAN, reversed
        add_seg(682, 170, 597, 85);        // alternating bit patterns
        add_seg(341, 85, 426, 170);
        add_seg(500, 255, 516, 0);
        add_seg(500, 0, 516, 255);         // same columns, partly above the new horizon
        add_seg(700, 199, 710, 199);       // row equal to reset horizon
        add_seg(720, 200, 730, 200);       // row just below reset horizon

        // random segments: mostly short mesh edges
        for (int i = 0; i < RAND_SEGS; i++) begin
            sel = $urandom_range(99);
            ya  = $urandom_range(255);
            yb  = (sel < 50) ? $urandom_range(255)
                             : ((ya + $urandom_range(40)) > 275 ? 255 :
                                (ya + $urandom_range(40) < 20) ? 0 :
                                 ya + $urandom_range(40) - 20);
            if (yb > 255)
                yb = 255;
            if (sel < 5)
                dx = 0;
            else if (sel < 10)
                dx = $urandom_range(1023, MAX_SPAN + 1);
            else
                dx = $urandom_range(20, 1);
            xl = $urandom_range(1023 - dx);
            if ($urandom_range(1))
                add_seg(xl, ya, xl + dx, yb);
            else
                add_seg(xl + dx, yb, xl, ya);
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (seg_acc_cnt < total_segs || pixel_exp_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Segments: %0d (%0d vertical, %0d clamped), columns checked: %0d, drawn: %0d",
                 seg_acc_cnt, flat_cnt, long_cnt, col_cnt, drawn_cnt);
        $display("Traffic: slow receiver, slow sender, then back-to-back; mismatches: %0d",
                 err_cnt);
        if (err_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/fhsd_pkg.sv
rtl/core/fhsd_hz_mem.sv
rtl/core/fhsd_divider.sv
rtl/core/floating_horizon_segment_draw_unit.sv
rtl/core/fhsd_checker.sv
test/floating_horizon_segment_draw_unit_tb.sv
